### rtl/cbe_pkg.sv
// cbe_pkg: shared types and constants of the cubic bezier easing unit
// fixed point format, register map, microcode word layout, sequencer states
// no dependencies
`default_nettype none

package cbe_pkg;

   // signed fixed point, ONE_Q means 1.0
   localparam int FRAC_BITS = 16;
   localparam int ONE_Q     = 1 << FRAC_BITS;
   localparam int EPS_Q     = (ONE_Q + 1000) / 2000;
   localparam int T_MAX     = 4 * ONE_Q;
   localparam int T_MIN     = -4 * ONE_Q;
   localparam int Y_MAX     = 3 * ONE_Q;
   localparam int Y_MIN     = -2 * ONE_Q;

   // datapath widths, sized for the full range of every register field
   localparam int T_W   = 20;
   localparam int K_W   = 22;
   localparam int TMP_W = 22;
   localparam int ACC_W = 32;
   localparam int OPA_W = 26;
   localparam int OPB_W = 24;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int PC_W       = 4;

   typedef logic        [16:0]           progress_type;
   typedef logic signed [18:0]           eased_type;
   typedef logic        [16:0]           coord_x_type;
   typedef logic signed [18:0]           coord_y_type;
   typedef logic        [7:0]            cap_type;
   typedef logic        [CSR_ADDR_W-1:0] csr_addr_type;
   typedef logic        [CSR_DATA_W-1:0] csr_data_type;
   typedef logic        [PC_W-1:0]       pc_type;

   typedef struct packed {
      coord_x_type a_x;
      coord_y_type a_y;
      coord_x_type b_x;
      coord_y_type b_y;
      cap_type     cap;
   } cfg_type;

   typedef enum logic [2:0] {
      REG_A_X,
      REG_A_Y,
      REG_B_X,
      REG_B_Y,
      REG_CAP
   } reg_index_type;

   // multiplier operand, addend, destination and jump selects
   typedef enum logic [2:0] {A_K0, A_ACC, A_T, A_R0, A_R} opa_sel_type;
   typedef enum logic [2:0] {B_T, B_R, B_R1, B_AY, B_BY} opb_sel_type;
   typedef enum logic [1:0] {ADD_ZERO, ADD_K1, ADD_K2, ADD_NEGX} add_sel_type;
   typedef enum logic [2:0] {DST_NONE, DST_ACC, DST_R0, DST_R1, DST_YS} dst_type;
   typedef enum logic [1:0] {JMP_NONE, JMP_CAP, JMP_NCONV} jmp_type;

   typedef struct packed {
      opa_sel_type a_sel;
      opb_sel_type b_sel;
      add_sel_type add_sel;
      dst_type     dst;
      logic        ys_acc;
      logic        upd_t;
      jmp_type     jmp;
      pc_type      target;
      logic        done;
      logic        out_x;
   } ucode_type;

   typedef struct packed {
      logic cap_hit;
      logic converged;
   } stat_type;

   typedef enum logic {SEQ_IDLE, SEQ_RUN} seq_state_type;

endpackage

`default_nettype wire

### rtl/cbe_if.sv
// cbe_if: request and response channel interfaces of the easing unit
// valid/ready handshake with the payload; depends on cbe_pkg
`default_nettype none

interface cbe_req_if import cbe_pkg::*; ();
   logic         valid;
   logic         ready;
   progress_type progress;

   modport source (output valid, output progress, input ready);
   modport sink   (input valid, input progress, output ready);
endinterface

interface cbe_rsp_if import cbe_pkg::*; ();
   logic      valid;
   logic      ready;
   eased_type eased;

   modport source (output valid, output eased, input ready);
   modport sink   (input valid, input eased, output ready);
endinterface

`default_nettype wire

### rtl/cbe_csr.sv
// cbe_csr: APB-style configuration registers (control points, iteration cap)
// depends on cbe_pkg
`default_nettype none

module cbe_csr import cbe_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         psel,
   input  wire logic         penable,
   input  wire logic         pwrite,
   input  wire csr_addr_type paddr,
   input  wire csr_data_type pwdata,
   output csr_data_type      prdata,
   output cfg_type           cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          wr_en;

   assign index = reg_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign wr_en = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            REG_A_X: cfg_in.a_x = pwdata[16:0];
            REG_A_Y: cfg_in.a_y = pwdata[18:0];
            REG_B_X: cfg_in.b_x = pwdata[16:0];
            REG_B_Y: cfg_in.b_y = pwdata[18:0];
            REG_CAP: cfg_in.cap = pwdata[7:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.a_x <= 17'd27525;
         cfg_ff.a_y <= 19'sd0;
         cfg_ff.b_x <= 17'd38011;
         cfg_ff.b_y <= 19'sd65536;
         cfg_ff.cap <= 8'd8;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (index)
         REG_A_X: prdata = CSR_DATA_W'(cfg_ff.a_x);
         REG_A_Y: prdata = CSR_DATA_W'($signed(cfg_ff.a_y));
         REG_B_X: prdata = CSR_DATA_W'(cfg_ff.b_x);
         REG_B_Y: prdata = CSR_DATA_W'($signed(cfg_ff.b_y));
         REG_CAP: prdata = CSR_DATA_W'(cfg_ff.cap);
         default: prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

### rtl/cbe_dpath.sv
// cbe_dpath: shared rounding multiplier, adder and working registers
// executes one control word per cycle; depends on cbe_pkg
`default_nettype none

module cbe_dpath import cbe_pkg::*; (
   input  wire logic         clock,
   input  wire logic         load,
   input  wire progress_type progress,
   input  wire cfg_type      cfg,
   input  wire ucode_type    ctl,
   input  wire logic         take,
   output stat_type          stat,
   output eased_type         result
);

   localparam int PROD_W = OPA_W + OPB_W;
   localparam logic signed [PROD_W-1:0] HALF_P  = PROD_W'(ONE_Q >> 1);
   localparam logic signed [ACC_W-1:0]  EPS_P   = ACC_W'(EPS_Q);
   localparam logic signed [ACC_W-1:0]  NEPS_P  = ACC_W'(-EPS_Q);
   localparam logic signed [ACC_W:0]    T_HI    = (ACC_W+1)'(T_MAX);
   localparam logic signed [ACC_W:0]    T_LO    = (ACC_W+1)'(T_MIN);
   localparam logic signed [ACC_W-1:0]  Y_HI    = ACC_W'(Y_MAX);
   localparam logic signed [ACC_W-1:0]  Y_LO    = ACC_W'(Y_MIN);

   progress_type             x_ff,   x_in;
   logic signed [T_W-1:0]    t_ff,   t_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [TMP_W-1:0]  r0_ff,  r0_in;
   logic signed [TMP_W-1:0]  r1_ff,  r1_in;
   logic signed [ACC_W-1:0]  ys_ff,  ys_in;
   cap_type                  cnt_ff, cnt_in;

   logic signed [K_W-1:0]    ax, bx, ax3, bx3, k0, k1, k2;
   logic signed [T_W:0]      r_val;
   logic signed [OPA_W-1:0]  op_a;
   logic signed [OPB_W-1:0]  op_b;
   logic signed [PROD_W-1:0] prod, prod_rnd;
   logic signed [ACC_W-1:0]  mul_q, addend, mul_sum, ys3;
   logic signed [ACC_W:0]    t_diff;
   logic signed [T_W-1:0]    t_sat;
   eased_type                y_sat;

   // polynomial coefficients of x(t); the user keeps cfg stable while a request is in flight, not enforced here
   assign ax  = $signed(K_W'(cfg.a_x));
   assign bx  = $signed(K_W'(cfg.b_x));
   assign ax3 = ax + (ax <<< 1);
   assign bx3 = bx + (bx <<< 1);
   assign k0  = K_W'(ONE_Q) + ax3 - bx3;
   assign k1  = bx3 - (ax3 <<< 1);
   assign k2  = ax3;

   assign r_val = (T_W+1)'(ONE_Q) - (T_W+1)'(t_ff);

   always_comb begin
      case (ctl.a_sel)
         A_K0:    op_a = OPA_W'(k0);
         A_ACC:   op_a = OPA_W'(acc_ff);
         A_T:     op_a = OPA_W'(t_ff);
         A_R0:    op_a = OPA_W'(r0_ff);
         A_R:     op_a = OPA_W'(r_val);
         default: op_a = '0;
      endcase
      case (ctl.b_sel)
         B_T:     op_b = OPB_W'(t_ff);
         B_R:     op_b = OPB_W'(r_val);
         B_R1:    op_b = OPB_W'(r1_ff);
         B_AY:    op_b = OPB_W'($signed(cfg.a_y));
         B_BY:    op_b = OPB_W'($signed(cfg.b_y));
         default: op_b = '0;
      endcase
      case (ctl.add_sel)
         ADD_ZERO: addend = '0;
         ADD_K1:   addend = ACC_W'(k1);
         ADD_K2:   addend = ACC_W'(k2);
         ADD_NEGX: addend = ACC_W'(0) - $signed(ACC_W'(x_ff));
         default:  addend = '0;
      endcase
   end

   // round to nearest, ties up: arithmetic shift after adding one half
   assign prod     = op_a * op_b;
   assign prod_rnd = prod + HALF_P;
   assign mul_q    = $signed(prod_rnd[FRAC_BITS +: ACC_W]);
   assign mul_sum  = mul_q + addend;
   assign ys3      = ys_ff + acc_ff + (acc_ff <<< 1);

   // newton-like step t - floor(ft/2), clamped
   assign t_diff = (ACC_W+1)'(t_ff) - (ACC_W+1)'(acc_ff >>> 1);
   always_comb begin
      if (t_diff > T_HI) begin
         t_sat = T_W'(T_HI);
      end else if (t_diff < T_LO) begin
         t_sat = T_W'(T_LO);
      end else begin
         t_sat = T_W'(t_diff);
      end
      if (ys_ff > Y_HI) begin
         y_sat = eased_type'(Y_HI);
      end else if (ys_ff < Y_LO) begin
         y_sat = eased_type'(Y_LO);
      end else begin
         y_sat = eased_type'(ys_ff);
      end
   end

   always_comb begin
      x_in   = x_ff;
      t_in   = t_ff;
      cnt_in = cnt_ff;
      acc_in = (ctl.dst == DST_ACC) ? mul_sum : acc_ff;
      r0_in  = (ctl.dst == DST_R0) ? TMP_W'(mul_sum) : r0_ff;
      r1_in  = (ctl.dst == DST_R1) ? TMP_W'(mul_sum) : r1_ff;
      if (ctl.dst == DST_YS) begin
         ys_in = mul_sum;
      end else if (ctl.ys_acc) begin
         ys_in = ys3;
      end else begin
         ys_in = ys_ff;
      end
      if (load) begin
         x_in   = progress;
         t_in   = $signed(T_W'(progress));
         cnt_in = '0;
      end else if (ctl.upd_t && take) begin
         t_in   = t_sat;
         cnt_in = cnt_ff + 8'd1;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      t_ff   <= t_in;
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      r0_ff  <= r0_in;
      r1_ff  <= r1_in;
      ys_ff  <= ys_in;
   end

   assign stat.cap_hit   = (cnt_ff == cfg.cap);
   assign stat.converged = (acc_ff <= EPS_P) && (acc_ff >= NEPS_P);
   assign result         = ctl.out_x ? eased_type'(x_ff) : y_sat;

endmodule

`default_nettype wire

### rtl/cbe_useq.sv
// cbe_useq: microcode sequencer with program rom, step counter and branches
// drives cbe_dpath control words; depends on cbe_pkg
`default_nettype none

module cbe_useq import cbe_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     start,
   input  wire logic     diag,
   input  wire stat_type stat,
   input  wire logic     out_free,
   output ucode_type     ctl,
   output logic          take,
   output logic          ready,
   output logic          fire
);

   localparam pc_type PC_LOOP = 4'd0;
   localparam pc_type PC_FIN  = 4'd4;
   localparam pc_type PC_PASS = 4'd13;

   localparam ucode_type UC_NOP = '{
      a_sel: A_T, b_sel: B_T, add_sel: ADD_ZERO, dst: DST_NONE, ys_acc: 1'b0,
      upd_t: 1'b0, jmp: JMP_NONE, target: PC_LOOP, done: 1'b0, out_x: 1'b0};

   function automatic ucode_type rom(input pc_type pc);
      ucode_type w;
      w = UC_NOP;
      case (pc)
         // ft = ((k0*t + k1)*t + k2)*t - x, leave once the cap is reached
         4'd0: begin
            w.a_sel = A_K0; w.add_sel = ADD_K1; w.dst = DST_ACC;
            w.jmp = JMP_CAP; w.target = PC_FIN;
         end
         4'd1: begin
            w.a_sel = A_ACC; w.add_sel = ADD_K2; w.dst = DST_ACC;
         end
         4'd2: begin
            w.a_sel = A_ACC; w.add_sel = ADD_NEGX; w.dst = DST_ACC;
         end
         4'd3: begin
            w.upd_t = 1'b1; w.jmp = JMP_NCONV; w.target = PC_LOOP;
         end
         // y(t) with r = 1 - t
         4'd4: begin
            w.a_sel = A_T; w.b_sel = B_T; w.dst = DST_R0;
         end
         4'd5: begin
            w.a_sel = A_R0; w.b_sel = B_T; w.dst = DST_YS;
         end
         4'd6: begin
            w.a_sel = A_R; w.b_sel = B_R; w.dst = DST_R1;
         end
         4'd7: begin
            w.a_sel = A_R0; w.b_sel = B_R; w.dst = DST_ACC;
         end
         4'd8: begin
            w.a_sel = A_ACC; w.b_sel = B_BY; w.dst = DST_ACC;
         end
         4'd9: begin
            w.a_sel = A_T; w.b_sel = B_R1; w.dst = DST_ACC; w.ys_acc = 1'b1;
         end
         4'd10: begin
            w.a_sel = A_ACC; w.b_sel = B_AY; w.dst = DST_ACC;
         end
         4'd11: begin
            w.ys_acc = 1'b1;
         end
         4'd12: begin
            w.done = 1'b1;
         end
         4'd13: begin
            w.done = 1'b1; w.out_x = 1'b1;
         end
         default: w = UC_NOP;
      endcase
      return w;
   endfunction

   seq_state_type state_ff, state_in;
   pc_type        pc_ff,    pc_in;
   ucode_type     uc;

   assign uc = rom(pc_ff);

   // next state and step
   always_comb begin
      state_in = state_ff;
      pc_in    = pc_ff;
      case (state_ff)
         SEQ_IDLE: begin
            if (start) begin
               state_in = SEQ_RUN;
               pc_in    = diag ? PC_PASS : PC_LOOP;
            end
         end
         SEQ_RUN: begin
            if (uc.done) begin
               if (out_free) begin
                  state_in = SEQ_IDLE;
               end
            end else if (take) begin
               pc_in = uc.target;
            end else begin
               pc_in = pc_ff + PC_W'(1);
            end
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      ready = (state_ff == SEQ_IDLE);
      ctl   = (state_ff == SEQ_RUN) ? uc : UC_NOP;
      fire  = (state_ff == SEQ_RUN) && uc.done && out_free;
      take  = 1'b0;
      if (state_ff == SEQ_RUN) begin
         case (uc.jmp)
            JMP_NONE:  take = 1'b0;
            JMP_CAP:   take = stat.cap_hit;
            JMP_NCONV: take = !stat.converged;
            default:   take = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         pc_ff    <= PC_LOOP;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
      end
   end

endmodule

`default_nettype wire

### rtl/cubic_bezier_easing_unit.sv
// channel   dir  handshake        payload
// req       in   valid/ready      progress  17b unsigned Q16 x
// rsp       out  valid/ready      eased     19b signed   Q16 y, saturated
// csr       in   apb psel/penable a_x, a_y, b_x, b_y, iteration cap
//
// one request at a time on the shared multiplier: refinement passes evaluate ft and update t
// until ft converges or the iteration cap ends them, then the y steps build the eased value;
// with diagonal control points x is passed through as y and both are skipped
// the next request is accepted only once the response has been issued
// reset is synchronous and clears the sequencer and the output valid, and loads the csr defaults
// a stalled response holds the sequencer on its last step and the next request waits
`default_nettype none

module cubic_bezier_easing_unit import cbe_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   cbe_req_if.sink           req,
   cbe_rsp_if.source         rsp,
   input  wire logic         psel,
   input  wire logic         penable,
   input  wire logic         pwrite,
   input  wire csr_addr_type paddr,
   input  wire csr_data_type pwdata,
   output csr_data_type      prdata,
   output logic              pready
);

   cfg_type   cfg;
   ucode_type ctl;
   stat_type  stat;
   eased_type result;
   logic      take, seq_ready, fire, accept, out_free, diag;

   logic      rsp_valid_ff, rsp_valid_in;
   eased_type rsp_eased_ff, rsp_eased_in;

   cbe_csr u_cbe_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .cfg     (cfg)
   );

   assign pready = 1'b1;

   // both control points on the diagonal: identity curve
   assign diag = ($signed({2'b00, cfg.a_x}) == cfg.a_y) &&
                 ($signed({2'b00, cfg.b_x}) == cfg.b_y);

   assign accept    = req.valid && seq_ready;
   assign req.ready = seq_ready;
   assign out_free  = !rsp_valid_ff || rsp.ready;

   cbe_useq u_cbe_useq (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .diag     (diag),
      .stat     (stat),
      .out_free (out_free),
      .ctl      (ctl),
      .take     (take),
      .ready    (seq_ready),
      .fire     (fire)
   );

   cbe_dpath u_cbe_dpath (
      .clock    (clock),
      .load     (accept),
      .progress (req.progress),
      .cfg      (cfg),
      .ctl      (ctl),
      .take     (take),
      .stat     (stat),
      .result   (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_eased_in = rsp_eased_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
         rsp_eased_in = result;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_eased_ff <= rsp_eased_in;
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.eased = rsp_eased_ff;

endmodule

`default_nettype wire

### rtl/cbe_checker.sv
// cbe_checker: port-level assertions for cubic_bezier_easing_unit
// bound to the top level below; depends on cbe_pkg
`default_nettype none

module cbe_checker import cbe_pkg::*; (
   input wire logic      clock,
   input wire logic      reset,
   input wire logic      req_valid,
   input wire logic      req_ready,
   input wire logic      rsp_valid,
   input wire logic      rsp_ready,
   input wire eased_type rsp_eased
);

   // response held while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_eased))
      else $error("response dropped or changed while stalled");

   // one request in flight
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   // saturation keeps y inside [-2, 3]
   a_eased_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_eased >= eased_type'(Y_MIN)) && (rsp_eased <= eased_type'(Y_MAX)))
      else $error("eased value outside saturation range");

   // no response appears in the cycle after an accept
   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> !rsp_valid)
      else $error("response too early");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("reset did not clear the channels");

endmodule

bind cubic_bezier_easing_unit cbe_checker u_cbe_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req.valid),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .rsp_eased (rsp.eased)
);

`default_nettype wire
